FILE: src/pews_pkg.sv
`timescale 1ns / 1ps
// Package for the pixel edge weight stream: shared constants, the control flag
// struct and the elaboration-time builder for the exponential weight table.
// No dependencies.
package pews_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned MAX_WIDTH_DEF   = 2048;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 3 * CH_W;
  localparam int unsigned IMG_W_W  = 12;
  localparam int unsigned IMG_H_W  = 16;
  localparam int unsigned CFG_D_W  = 16;
  localparam int unsigned ROM_DEPTH = 256;

  // Register reset values.
  localparam logic [IMG_W_W-1:0] IMG_W_RST = 12'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 16'd480;

  // exp(-0.7) and 1e-6, both scaled by 2^32.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd2132817639;
  localparam logic [63:0] EPS_Q32      = 64'd4295;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Border and frame flags of one item, from the raster counters.
  typedef struct packed {
    logic up_valid;
    logic left_valid;
    logic frame_last;
  } flags_t;

  // Table entry n: exp(-0.7*n) + 1e-6 as an unsigned fraction with wbits
  // fraction bits, saturated to all ones. Evaluated at elaboration only.
  function automatic logic [23:0] weight_entry(input int unsigned n,
                                               input int unsigned wbits);
    logic [63:0] v;
    logic [63:0] q;
    logic [63:0] maxw;
    int unsigned sh;
    v    = 64'd1 << 32;
    maxw = (64'd1 << wbits) - 64'd1;
    sh   = 32 - wbits;
    for (int unsigned k = 0; k < n; k++) begin
      v = (v * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    q = (v + EPS_Q32 + (64'd1 << (sh - 1))) >> sh;
    return (q > maxw) ? maxw[23:0] : q[23:0];
  endfunction

endpackage

FILE: src/pews_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pews_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write to the same address in one cycle return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pews_raster.sv
`timescale 1ns / 1ps
// Raster position tracking: image size registers, column and row counters,
// border and last-pixel flags. Depends on pews_pkg.
module pews_raster import pews_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [CFG_D_W-1:0]           cfg_wdata_i,
  input  logic                         step_i,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output flags_t                       flags_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (AW + 1 > IMG_W_W + 1) ? AW + 1 : IMG_W_W + 1;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic [AW-1:0]      col_q, col_d;
  logic [IMG_H_W-1:0] row_q, row_d;
  logic [CW-1:0]      width_ext;
  logic [CW-1:0]      last_col;
  logic [IMG_H_W-1:0] last_row;
  logic               row_end;
  logic               frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_RST;
      height_q <= IMG_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // A width of zero acts as one; a width beyond the line store is clamped.
  assign width_ext = CW'(width_q);

  always_comb begin
    if (width_ext == '0) begin
      last_col = '0;
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = width_ext - CW'(1);
    end
  end

  assign last_row  = (height_q == '0) ? '0 : height_q - IMG_H_W'(1);
  assign row_end   = CW'(col_q) >= last_col;
  assign frame_end = row_end && (row_q >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + IMG_H_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o              = col_q;
  assign flags_o.up_valid   = (row_q != '0);
  assign flags_o.left_valid = (col_q != '0);
  assign flags_o.frame_last = frame_end;

endmodule

FILE: src/pews_weight.sv
`timescale 1ns / 1ps
// Edge weight of two pixels: largest absolute channel difference looked up in
// the exponential weight table. Depends on pews_pkg.
module pews_weight import pews_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic [PIX_W-1:0]       pix_a_i,
  input  logic [PIX_W-1:0]       pix_b_i,
  input  logic                   valid_i,
  output logic [WEIGHT_BITS-1:0] weight_o
);

  logic [WEIGHT_BITS-1:0] rom [ROM_DEPTH];
  logic [CH_W-1:0]        diff [3];
  logic [CH_W-1:0]        max_ab;
  logic [CH_W-1:0]        max_all;

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign rom[g] = WEIGHT_BITS'(weight_entry(g, WEIGHT_BITS));
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pix_a_i[c*CH_W +: CH_W] > pix_b_i[c*CH_W +: CH_W]) begin
        diff[c] = pix_a_i[c*CH_W +: CH_W] - pix_b_i[c*CH_W +: CH_W];
      end else begin
        diff[c] = pix_b_i[c*CH_W +: CH_W] - pix_a_i[c*CH_W +: CH_W];
      end
    end
  end

  assign max_ab  = (diff[1] > diff[0]) ? diff[1] : diff[0];
  assign max_all = (diff[2] > max_ab) ? diff[2] : max_ab;

  // Border weights read as zero.
  assign weight_o = valid_i ? rom[max_all] : '0;

endmodule

FILE: src/pixel_edge_weight_stream_core.sv
`timescale 1ns / 1ps
// Top level of the pixel edge weight stream: input stage, line store, weight
// units and output register. Depends on pews_pkg, pews_ram, pews_raster, pews_weight.
//
// Usage
// - Pixels enter in raster order on the input channel (in_valid_i/in_ready_o,
//   red_i, green_i, blue_i). For every item one result leaves on the output
//   channel (out_valid_o/out_ready_i): the weights to the pixel above and on
//   the left, their border flags and a flag on the last pixel of the image.
// - The image size is set through the write port (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) while no item is in flight; index 0 is the width, 1 the height.
// - An item accepted at a clock edge is written into the stage register, and
//   its result is loaded into the output register when the stage register
//   moves on, and is then shown on the output channel.
// - Throughput is one item per cycle while the receiver takes results. The line
//   store is a RAM with one write and one registered read port; each item
//   reads the pixel above and writes itself at the same column when accepted.
// - When the receiver stalls, the output register holds its result and the
//   stage register takes one more item; input ready drops only when both are
//   full, so nothing is lost or repeated.
// - Reset clears the counters, the previous pixel and both valid flags and
//   loads a 640 by 480 image. The line store is not cleared: the first row
//   never uses what it reads.
module pixel_edge_weight_stream_core import pews_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [CFG_D_W-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CH_W-1:0]        red_i,
  input  logic [CH_W-1:0]        green_i,
  input  logic [CH_W-1:0]        blue_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [WEIGHT_BITS-1:0] up_weight_o,
  output logic                   up_valid_o,
  output logic [WEIGHT_BITS-1:0] left_weight_o,
  output logic                   left_valid_o,
  output logic                   frame_last_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic                   in_accept;
  logic                   s1_move;
  logic [PIX_W-1:0]       pix;
  logic [AW-1:0]          col;
  flags_t                 flags;
  logic [PIX_W-1:0]       line_rdata;
  logic [PIX_W-1:0]       prev_pix_q;

  logic                   s1_valid_q;
  logic [PIX_W-1:0]       s1_pix_q;
  logic [PIX_W-1:0]       s1_prev_q;
  flags_t                 s1_flags_q;

  logic [WEIGHT_BITS-1:0] up_w;
  logic [WEIGHT_BITS-1:0] left_w;

  logic                   out_valid_q;
  logic [WEIGHT_BITS-1:0] up_weight_q;
  logic [WEIGHT_BITS-1:0] left_weight_q;
  flags_t                 out_flags_q;

  // The stage register moves on whenever the output register is empty or is
  // being emptied; a new item may enter whenever the stage register moves on.
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Pixels are packed with red in the low byte, as the channels are ordered.
  assign pix = {blue_i, green_i, red_i};

  pews_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (in_accept),
    .col_o       (col),
    .flags_o     (flags)
  );

  // The read returns the pixel stored one row earlier at this column, before
  // the current pixel replaces it. The read data holds until the next item is
  // accepted, which keeps it aligned with the stage register during a stall.
  pews_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col),
    .wdata_i (pix),
    .re_i    (in_accept),
    .raddr_i (col),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pix_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_pix_q <= pix;
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= pix;
      s1_prev_q  <= prev_pix_q;
      s1_flags_q <= flags;
    end
  end

  pews_weight #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_up_weight (
    .pix_a_i  (s1_pix_q),
    .pix_b_i  (line_rdata),
    .valid_i  (s1_flags_q.up_valid),
    .weight_o (up_w)
  );

  pews_weight #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_left_weight (
    .pix_a_i  (s1_pix_q),
    .pix_b_i  (s1_prev_q),
    .valid_i  (s1_flags_q.left_valid),
    .weight_o (left_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      up_weight_q   <= up_w;
      left_weight_q <= left_w;
      out_flags_q   <= s1_flags_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign up_weight_o   = up_weight_q;
  assign up_valid_o    = out_flags_q.up_valid;
  assign left_weight_o = left_weight_q;
  assign left_valid_o  = out_flags_q.left_valid;
  assign frame_last_o  = out_flags_q.frame_last;

endmodule
